// ----- hw/rtl/mtl_pkg.sv -----
// mixer tile layout package: widths, register codes, placement kinds and
// the structs passed between the pipeline modules
// no dependencies
package mtl_pkg;

  // field and datapath widths
  localparam int DIM_W        = 13;  // frame and tile size, up to 4096
  localparam int POS_W        = 12;  // tile corner coordinate
  localparam int IDX_W        = 6;   // tile index
  localparam int CNT_W        = 7;   // source count
  localparam int SLOT_W       = 6;   // focus slot count and divisor, up to 32
  localparam int SIDE_W       = 4;   // grid side, up to 8
  localparam int ROW_W        = 5;   // grid row of a tile
  localparam int DVD_W        = 17;  // dividend, frame size times (slots - 1)
  localparam int QUO_W        = 13;  // quotient, never above the frame size
  localparam int FAC_X_W      = 5;   // column factor for the x multiply
  localparam int FAC_Y_W      = 6;   // row factor for the y multiply
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 13;

  // reciprocal divide: quotient estimate is (a * floor(2^18 / d)) >> 18
  localparam int RECIP_SHIFT  = 18;
  localparam int RECIP_W      = 18;
  // grid row: idx / side is exactly (idx * ceil(2^9 / side)) >> 9
  localparam int GRID_SHIFT   = 9;
  localparam int GRID_RECIP_W = 9;

  localparam logic [DIM_W-1:0]  FRAME_LIMIT     = 13'd4096;
  localparam logic [CNT_W-1:0]  MAX_SOURCES     = 7'd64;
  localparam logic [CNT_W-1:0]  FOCUS_MIN_SLOTS = 7'd6;
  localparam logic [SIDE_W-1:0] GRID_MIN_SIDE   = 4'd2;

  localparam logic [DIM_W-1:0]  FRAME_W_RESET   = 13'd640;
  localparam logic [DIM_W-1:0]  FRAME_H_RESET   = 13'd480;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_SOURCE_COUNT = 2'd2,
    REG_FOCUS_LAYOUT = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_HIDDEN = 3'd0,
    KIND_MAIN   = 3'd1,
    KIND_RIGHT  = 3'd2,
    KIND_BOTTOM = 3'd3,
    KIND_GRID   = 3'd4
  } place_kind_e;

  // layout values derived from the configuration registers
  typedef struct packed {
    logic [DIM_W-1:0]        frame_w;
    logic [DIM_W-1:0]        frame_h;
    logic                    focus;
    logic [SLOT_W-1:0]       slots;
    logic [SIDE_W-1:0]       side;
    logic [SLOT_W-1:0]       divisor;
    logic [RECIP_W-1:0]      div_recip;
    logic [GRID_RECIP_W-1:0] grid_recip;
  } layout_t;

  // per-tile placement control carried down the pipeline
  typedef struct packed {
    place_kind_e          kind;
    logic [FAC_X_W-1:0]   fac_x;
    logic [FAC_Y_W-1:0]   fac_y;
  } tile_ctl_t;

  // front end to divider correction
  typedef struct packed {
    tile_ctl_t          ctl;
    logic [DVD_W-1:0]   dvd_x;
    logic [DVD_W-1:0]   dvd_y;
    logic [QUO_W-1:0]   quo_x;
    logic [QUO_W-1:0]   quo_y;
  } div_item_t;

  // divider correction to placement
  typedef struct packed {
    tile_ctl_t          ctl;
    logic [QUO_W-1:0]   tile_w;
    logic [QUO_W-1:0]   tile_h;
  } place_item_t;

endpackage

// ----- hw/rtl/mtl_if.sv -----
// tile request and rectangle result channels of the mixer tile layout
// depends on mtl_pkg
interface mtl_tile_if
  import mtl_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] tile_index;
  logic             is_focused;

  modport source (output valid, tile_index, is_focused, input ready);
  modport sink   (input valid, tile_index, is_focused, output ready);
endinterface

interface mtl_rect_if
  import mtl_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] rect_x;
  logic [POS_W-1:0] rect_y;
  logic [DIM_W-1:0] rect_w;
  logic [DIM_W-1:0] rect_h;
  logic             visible;

  modport source (output valid, rect_x, rect_y, rect_w, rect_h, visible, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_w, rect_h, visible, output ready);
endinterface

// ----- hw/rtl/mtl_cfg_regs.sv -----
// configuration registers and the layout values derived from them
// depends on mtl_pkg
module mtl_cfg_regs
  import mtl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output layout_t               layout
);

  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  logic [CNT_W-1:0] source_count;
  logic             focus_layout;

  logic [CNT_W-1:0]  count_sat;
  logic [CNT_W-1:0]  slots_raw;
  logic [SIDE_W-1:0] side;
  logic [SLOT_W-1:0] slots;
  logic [SLOT_W-1:0] divisor;

  // floor(2^18 / d) for the divisors that occur
  function automatic logic [RECIP_W-1:0] div_recip_of(input logic [SLOT_W-1:0] d);
    logic [RECIP_W-1:0] r;
    case (d)
      6'd2:    r = 18'd131072;
      6'd3:    r = 18'd87381;
      6'd4:    r = 18'd65536;
      6'd5:    r = 18'd52428;
      6'd6:    r = 18'd43690;
      6'd7:    r = 18'd37449;
      6'd8:    r = 18'd32768;
      6'd9:    r = 18'd29127;
      6'd10:   r = 18'd26214;
      6'd11:   r = 18'd23831;
      6'd12:   r = 18'd21845;
      6'd13:   r = 18'd20164;
      6'd14:   r = 18'd18724;
      6'd15:   r = 18'd17476;
      6'd16:   r = 18'd16384;
      6'd17:   r = 18'd15420;
      6'd18:   r = 18'd14563;
      6'd19:   r = 18'd13797;
      6'd20:   r = 18'd13107;
      6'd21:   r = 18'd12483;
      6'd22:   r = 18'd11915;
      6'd23:   r = 18'd11397;
      6'd24:   r = 18'd10922;
      6'd25:   r = 18'd10485;
      6'd26:   r = 18'd10082;
      6'd27:   r = 18'd9709;
      6'd28:   r = 18'd9362;
      6'd29:   r = 18'd9039;
      6'd30:   r = 18'd8738;
      6'd31:   r = 18'd8456;
      6'd32:   r = 18'd8192;
      default: r = '0;
    endcase
    return r;
  endfunction

  // ceil(2^9 / side), exact for row = idx / side over the whole index range
  function automatic logic [GRID_RECIP_W-1:0] grid_recip_of(input logic [SIDE_W-1:0] s);
    logic [GRID_RECIP_W-1:0] r;
    case (s)
      4'd2:    r = 9'd256;
      4'd3:    r = 9'd171;
      4'd4:    r = 9'd128;
      4'd5:    r = 9'd103;
      4'd6:    r = 9'd86;
      4'd7:    r = 9'd74;
      4'd8:    r = 9'd64;
      default: r = '0;
    endcase
    return r;
  endfunction

  // smallest side of at least two whose square covers the count
  function automatic logic [SIDE_W-1:0] grid_side_of(input logic [CNT_W-1:0] n);
    logic [SIDE_W-1:0] s;
    if (n <= 7'd4)       s = GRID_MIN_SIDE;
    else if (n <= 7'd9)  s = 4'd3;
    else if (n <= 7'd16) s = 4'd4;
    else if (n <= 7'd25) s = 4'd5;
    else if (n <= 7'd36) s = 4'd6;
    else if (n <= 7'd49) s = 4'd7;
    else                 s = 4'd8;
    return s;
  endfunction

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= FRAME_W_RESET;
      frame_height <= FRAME_H_RESET;
      source_count <= '0;
      focus_layout <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_reg_e'(cfg_index))
        REG_FRAME_WIDTH:  frame_width  <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= cfg_data[DIM_W-1:0];
        REG_SOURCE_COUNT: source_count <= cfg_data[CNT_W-1:0];
        REG_FOCUS_LAYOUT: focus_layout <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // saturation, slot count and grid side
  always_comb begin
    count_sat = (source_count > MAX_SOURCES) ? MAX_SOURCES : source_count;
    slots_raw = count_sat + 7'd1;
    if (slots_raw < FOCUS_MIN_SLOTS) begin
      slots_raw = FOCUS_MIN_SLOTS;
    end
    slots   = slots_raw[SLOT_W:1];
    side    = grid_side_of(count_sat);
    divisor = focus_layout ? slots : SLOT_W'(side);
  end

  always_comb begin
    layout.frame_w    = (frame_width > FRAME_LIMIT) ? FRAME_LIMIT : frame_width;
    layout.frame_h    = (frame_height > FRAME_LIMIT) ? FRAME_LIMIT : frame_height;
    layout.focus      = focus_layout;
    layout.slots      = slots;
    layout.side       = side;
    layout.divisor    = divisor;
    layout.div_recip  = div_recip_of(divisor);
    layout.grid_recip = grid_recip_of(side);
  end

endmodule

// ----- hw/rtl/mtl_front.sv -----
// front end: tile decode, grid row and column, dividends and the
// reciprocal quotient estimate (two register stages)
// depends on mtl_pkg and mtl_if
module mtl_front
  import mtl_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  layout_t         layout,
  mtl_tile_if.sink        tile_in,
  output logic            out_valid,
  input  logic            out_ready,
  output div_item_t       out_item
);

  localparam int GPROD_W = IDX_W + GRID_RECIP_W;
  localparam int RPROD_W = DVD_W + RECIP_W;
  localparam int CPROD_W = ROW_W + SIDE_W;

  // stage 1 registers
  logic             v1;
  tile_ctl_t        ctl1;
  logic [IDX_W-1:0] idx1;
  logic [ROW_W-1:0] row1;
  logic [DVD_W-1:0] dvd_x1;
  logic [DVD_W-1:0] dvd_y1;

  logic en1;
  logic en2;

  // stage 1 logic
  logic [GPROD_W-1:0] grid_prod;
  logic [ROW_W-1:0]   row;
  logic [SLOT_W-1:0]  slots_m1;
  logic [CNT_W-1:0]   slots_x2;
  logic [CNT_W-1:0]   col_back;
  logic               main_tile;
  tile_ctl_t          ctl_d;
  logic [DVD_W-1:0]   dvd_x_d;
  logic [DVD_W-1:0]   dvd_y_d;

  // stage 2 logic
  logic [CPROD_W-1:0] col_prod;
  logic [IDX_W-1:0]   col;
  logic [RPROD_W-1:0] prod_x;
  logic [RPROD_W-1:0] prod_y;
  div_item_t          item_d;

  // stage enables, bubbles are squeezed out
  assign en2           = !out_valid || out_ready;
  assign en1           = !v1 || en2;
  assign tile_in.ready = en1;

  // decode of one tile
  always_comb begin
    grid_prod = GPROD_W'(tile_in.tile_index) * GPROD_W'(layout.grid_recip);
    row       = grid_prod[GRID_SHIFT +: ROW_W];
    slots_m1  = layout.slots - 6'd1;
    slots_x2  = CNT_W'(layout.slots) << 1;
    col_back  = slots_x2 - 7'd2 - CNT_W'(tile_in.tile_index);
    main_tile = layout.focus && tile_in.is_focused;

    ctl_d.fac_x = col_back[FAC_X_W-1:0];
    ctl_d.fac_y = tile_in.tile_index;
    if (layout.focus) begin
      if (tile_in.is_focused) begin
        ctl_d.kind = KIND_MAIN;
      end else if (CNT_W'(tile_in.tile_index) < CNT_W'(layout.slots)) begin
        ctl_d.kind = KIND_RIGHT;
      end else if (CNT_W'(tile_in.tile_index) < slots_x2 - 7'd1) begin
        ctl_d.kind = KIND_BOTTOM;
      end else begin
        ctl_d.kind = KIND_HIDDEN;
      end
    end else begin
      ctl_d.fac_y = FAC_Y_W'(row);
      ctl_d.kind  = (ROW_W'(layout.side) > row) ? KIND_GRID : KIND_HIDDEN;
    end

    // in focus layout the focused tile divides frame * (slots - 1), all others the frame
    if (main_tile) begin
      dvd_x_d = DVD_W'(layout.frame_w) * DVD_W'(slots_m1);
      dvd_y_d = DVD_W'(layout.frame_h) * DVD_W'(slots_m1);
    end else begin
      dvd_x_d = DVD_W'(layout.frame_w);
      dvd_y_d = DVD_W'(layout.frame_h);
    end
  end

  // stage 1 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= tile_in.valid;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (en1 && tile_in.valid) begin
      ctl1   <= ctl_d;
      idx1   <= tile_in.tile_index;
      row1   <= row;
      dvd_x1 <= dvd_x_d;
      dvd_y1 <= dvd_y_d;
    end
  end

  // grid column and reciprocal quotient estimate
  always_comb begin
    col_prod = CPROD_W'(row1) * CPROD_W'(layout.side);
    col      = idx1 - col_prod[IDX_W-1:0];
    prod_x   = RPROD_W'(dvd_x1) * RPROD_W'(layout.div_recip);
    prod_y   = RPROD_W'(dvd_y1) * RPROD_W'(layout.div_recip);

    item_d.ctl   = ctl1;
    if (ctl1.kind == KIND_GRID) begin
      item_d.ctl.fac_x = col[FAC_X_W-1:0];
    end
    item_d.dvd_x = dvd_x1;
    item_d.dvd_y = dvd_y1;
    item_d.quo_x = prod_x[RECIP_SHIFT +: QUO_W];
    item_d.quo_y = prod_y[RECIP_SHIFT +: QUO_W];
  end

  // stage 2 valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= v1;
    end
  end

  // stage 2 payload
  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      out_item <= item_d;
    end
  end

endmodule

// ----- hw/rtl/mtl_div_fix.sv -----
// divider correction: remainder of the quotient estimate and a single
// increment step (two register stages)
// depends on mtl_pkg
module mtl_div_fix
  import mtl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  layout_t     layout,
  input  logic        in_valid,
  output logic        in_ready,
  input  div_item_t   in_item,
  output logic        out_valid,
  input  logic        out_ready,
  output place_item_t out_item
);

  localparam int MPROD_W = QUO_W + SLOT_W;

  logic             v1;
  tile_ctl_t        ctl1;
  logic [QUO_W-1:0] quo_x1;
  logic [QUO_W-1:0] quo_y1;
  logic [DVD_W-1:0] rem_x1;
  logic [DVD_W-1:0] rem_y1;

  logic en1;
  logic en2;

  logic [MPROD_W-1:0] back_x;
  logic [MPROD_W-1:0] back_y;
  logic [DVD_W-1:0]   rem_x_d;
  logic [DVD_W-1:0]   rem_y_d;
  logic [DVD_W-1:0]   div_ext;
  place_item_t        item_d;

  assign en2      = !out_valid || out_ready;
  assign en1      = !v1 || en2;
  assign in_ready = en1;
  assign div_ext  = DVD_W'(layout.divisor);

  // remainder left by the estimate
  always_comb begin
    back_x  = MPROD_W'(in_item.quo_x) * MPROD_W'(layout.divisor);
    back_y  = MPROD_W'(in_item.quo_y) * MPROD_W'(layout.divisor);
    rem_x_d = in_item.dvd_x - back_x[DVD_W-1:0];
    rem_y_d = in_item.dvd_y - back_y[DVD_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      ctl1   <= in_item.ctl;
      quo_x1 <= in_item.quo_x;
      quo_y1 <= in_item.quo_y;
      rem_x1 <= rem_x_d;
      rem_y1 <= rem_y_d;
    end
  end

  // estimate is low by at most one
  always_comb begin
    item_d.ctl    = ctl1;
    item_d.tile_w = (rem_x1 >= div_ext) ? quo_x1 + 13'd1 : quo_x1;
    item_d.tile_h = (rem_y1 >= div_ext) ? quo_y1 + 13'd1 : quo_y1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en2) begin
      out_valid <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && v1) begin
      out_item <= item_d;
    end
  end

  // a single correction step must be enough
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    v1 |-> (rem_x1 < (div_ext << 1)) && (rem_y1 < (div_ext << 1)))
    else $error("quotient estimate off by more than one");

endmodule

// ----- hw/rtl/mtl_place.sv -----
// placement: tile corner from size and row or column factors, then the
// result register that drives the rectangle channel
// depends on mtl_pkg and mtl_if
module mtl_place
  import mtl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  layout_t     layout,
  input  logic        in_valid,
  output logic        in_ready,
  input  place_item_t in_item,
  mtl_rect_if.source  rect_out
);

  localparam int XPROD_W = QUO_W + FAC_X_W;
  localparam int YPROD_W = QUO_W + FAC_Y_W;

  logic en;

  logic [XPROD_W-1:0] mul_x;
  logic [YPROD_W-1:0] mul_y;
  logic [DIM_W-1:0]   edge_x;
  logic [DIM_W-1:0]   edge_y;
  logic [POS_W-1:0]   x_d;
  logic [POS_W-1:0]   y_d;
  logic [DIM_W-1:0]   w_d;
  logic [DIM_W-1:0]   h_d;
  logic               vis_d;

  assign en       = !rect_out.valid || rect_out.ready;
  assign in_ready = en;

  // corner selection per placement kind
  always_comb begin
    mul_x  = XPROD_W'(in_item.tile_w) * XPROD_W'(in_item.ctl.fac_x);
    mul_y  = YPROD_W'(in_item.tile_h) * YPROD_W'(in_item.ctl.fac_y);
    edge_x = layout.frame_w - in_item.tile_w;
    edge_y = layout.frame_h - in_item.tile_h;
    x_d    = '0;
    y_d    = '0;
    w_d    = in_item.tile_w;
    h_d    = in_item.tile_h;
    vis_d  = 1'b1;
    case (in_item.ctl.kind)
      KIND_GRID: begin
        x_d = mul_x[POS_W-1:0];
        y_d = mul_y[POS_W-1:0];
      end
      KIND_RIGHT: begin
        x_d = edge_x[POS_W-1:0];
        y_d = mul_y[POS_W-1:0];
      end
      KIND_BOTTOM: begin
        x_d = mul_x[POS_W-1:0];
        y_d = edge_y[POS_W-1:0];
      end
      KIND_MAIN: ;
      default: begin
        w_d   = '0;
        h_d   = '0;
        vis_d = 1'b0;
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_out.valid <= 1'b0;
    end else if (en) begin
      rect_out.valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && in_valid) begin
      rect_out.rect_x  <= x_d;
      rect_out.rect_y  <= y_d;
      rect_out.rect_w  <= w_d;
      rect_out.rect_h  <= h_d;
      rect_out.visible <= vis_d;
    end
  end

  // hidden tiles carry an all-zero rectangle
  a_hidden_zero: assert property (@(posedge clk) disable iff (rst)
    rect_out.valid && !rect_out.visible |->
      rect_out.rect_x == '0 && rect_out.rect_y == '0 &&
      rect_out.rect_w == '0 && rect_out.rect_h == '0)
    else $error("hidden tile with nonzero rectangle");

  // no tile is larger than the frame
  a_size_bound: assert property (@(posedge clk) disable iff (rst)
    rect_out.valid |->
      rect_out.rect_w <= layout.frame_w && rect_out.rect_h <= layout.frame_h)
    else $error("tile larger than frame");

endmodule

// ----- hw/rtl/mixer_tile_layout.sv -----
// mixer tile layout top level: configuration registers and the five stage
// placement pipeline
// depends on mtl_pkg, mtl_if, mtl_cfg_regs, mtl_front, mtl_div_fix, mtl_place

// Computes the rectangle of one source tile in the mixed output frame, in
// square grid or focus layout. A tile transaction is taken every clock
// cycle while the output side keeps up. The five register stages are
// tile decode with the focus dividend product, the reciprocal multiply,
// the remainder multiply, the quotient correction, and the corner
// multiply with the result register. Each stage holds its item during a
// stall and empty stages are filled, so input is still taken while a
// result waits, until every stage is full. Configuration writes take
// effect on the next cycle and need no clearing pass; write them only
// while no tile is in flight.
module mixer_tile_layout
  import mtl_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  mtl_tile_if.sink              tile_in,
  mtl_rect_if.source            rect_out
);

  layout_t     layout;
  logic        front_valid;
  logic        front_ready;
  div_item_t   front_item;
  logic        fix_valid;
  logic        fix_ready;
  place_item_t fix_item;

  mtl_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .layout    (layout)
  );

  mtl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .layout    (layout),
    .tile_in   (tile_in),
    .out_valid (front_valid),
    .out_ready (front_ready),
    .out_item  (front_item)
  );

  mtl_div_fix u_div_fix (
    .clk       (clk),
    .rst       (rst),
    .layout    (layout),
    .in_valid  (front_valid),
    .in_ready  (front_ready),
    .in_item   (front_item),
    .out_valid (fix_valid),
    .out_ready (fix_ready),
    .out_item  (fix_item)
  );

  mtl_place u_place (
    .clk      (clk),
    .rst      (rst),
    .layout   (layout),
    .in_valid (fix_valid),
    .in_ready (fix_ready),
    .in_item  (fix_item),
    .rect_out (rect_out)
  );

endmodule

// ----- dv/tb_mixer_tile_layout.sv -----
// testbench for mixer_tile_layout: directed and random tile transactions with
// a predictor of the tile rectangle, checked against every result in order
// depends on mtl_pkg, mtl_if and the mixer_tile_layout rtl
module tb_mixer_tile_layout
  import mtl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 5;
  localparam int PIPE_SLACK    = 8;
  localparam int STALL_LIMIT   = 5000;
  localparam int HOLD_CYCLES   = 200;
  localparam int REPORT_MAX    = 10;
  localparam int ITEMS_PER_SET = 100;

  // layout limits of the mixer
  localparam int FRAME_CAP   = 4096;
  localparam int SOURCE_CAP  = 64;
  localparam int FOCUS_FLOOR = 6;
  localparam int GRID_FLOOR  = 2;

  typedef struct packed {
    logic [POS_W-1:0] x;
    logic [POS_W-1:0] y;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic             vis;
  } tile_rect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mtl_tile_if tile_if ();
  mtl_rect_if rect_if ();

  mixer_tile_layout dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .tile_in  (tile_if),
    .rect_out (rect_if)
  );

  // shadow of the layout registers, reset values
  logic [DIM_W-1:0] lay_frame_w = 13'd640;
  logic [DIM_W-1:0] lay_frame_h = 13'd480;
  logic [CNT_W-1:0] lay_sources = '0;
  logic             lay_focus   = 1'b0;

  tile_rect_t rect_expect[$];
  int fail_count     = 0;
  int quiet_cycles   = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit rx_hold        = 1'b0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // rectangle of one tile under the current layout
  function automatic tile_rect_t place_tile(input logic [IDX_W-1:0] idx, input logic foc);
    int unsigned fw, fh, srcs, slots, side, tw, th, px, py, pw, ph;
    bit shown;
    tile_rect_t r;
    fw = (lay_frame_w > FRAME_CAP) ? FRAME_CAP : lay_frame_w;
    fh = (lay_frame_h > FRAME_CAP) ? FRAME_CAP : lay_frame_h;
    srcs = (lay_sources > SOURCE_CAP) ? SOURCE_CAP : lay_sources;
    px = 0; py = 0; pw = 0; ph = 0; shown = 1'b0;
    if (lay_focus) begin
      slots = srcs + 1;
      if (slots < FOCUS_FLOOR) slots = FOCUS_FLOOR;
      slots = slots / 2;
      if (foc) begin
        pw = fw * (slots - 1) / slots;
        ph = fh * (slots - 1) / slots;
        shown = 1'b1;
      end else begin
        tw = fw / slots;
        th = fh / slots;
        // right column first, then leftward along the bottom row
        if (idx < slots) begin
          pw = tw; ph = th;
          px = fw - tw;
          py = th * idx;
          shown = 1'b1;
        end else if (idx < slots * 2 - 1) begin
          pw = tw; ph = th;
          px = tw * (slots * 2 - 2 - idx);
          py = fh - th;
          shown = 1'b1;
        end
      end
    end else begin
      side = GRID_FLOOR;
      while (side * side < srcs) side++;
      if (idx / side < side) begin
        pw = fw / side;
        ph = fh / side;
        px = pw * (idx % side);
        py = ph * (idx / side);
        shown = 1'b1;
      end
    end
    r.x = px[POS_W-1:0];
    r.y = py[POS_W-1:0];
    r.w = pw[DIM_W-1:0];
    r.h = ph[DIM_W-1:0];
    r.vis = shown;
    return r;
  endfunction

  // register write, shadow follows once the write edge has passed
  task automatic write_reg(input cfg_reg_e sel, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= value;
    @(posedge clk);
    case (sel)
      REG_FRAME_WIDTH:  lay_frame_w = value;
      REG_FRAME_HEIGHT: lay_frame_h = value;
      REG_SOURCE_COUNT: lay_sources = value[CNT_W-1:0];
      REG_FOCUS_LAYOUT: lay_focus   = value[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // stop offering tiles and let every pending rectangle come out
  task automatic wait_idle();
    @(negedge clk);
    tile_if.valid <= 1'b0;
    while (rect_expect.size() != 0) @(posedge clk);
    repeat (PIPE_SLACK) @(posedge clk);
  endtask

  task automatic set_layout(input logic [CFG_DATA_W-1:0] fw, input logic [CFG_DATA_W-1:0] fh,
                            input logic [CFG_DATA_W-1:0] srcs, input logic foc);
    wait_idle();
    write_reg(REG_FRAME_WIDTH, fw);
    write_reg(REG_FRAME_HEIGHT, fh);
    write_reg(REG_SOURCE_COUNT, srcs);
    write_reg(REG_FOCUS_LAYOUT, {{(CFG_DATA_W-1){1'b0}}, foc});
  endtask

  // one tile transaction; valid stays high for a following tile
  task automatic send_tile(input logic [IDX_W-1:0] idx, input logic foc);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      tile_if.valid <= 1'b0;
    end
    @(negedge clk);
    tile_if.valid      <= 1'b1;
    tile_if.tile_index <= idx;
    tile_if.is_focused <= foc;
    do @(posedge clk); while (!tile_if.ready);
    rect_expect.push_back(place_tile(idx, foc));
  endtask

  // mostly tiles that land in a slot, some past the end
  task automatic send_random_tile();
    int unsigned n, span;
    logic [IDX_W-1:0] idx;
    logic foc;
    n = (lay_sources > SOURCE_CAP) ? SOURCE_CAP : lay_sources;
    if (lay_focus) begin
      span = ((n + 1 < FOCUS_FLOOR) ? FOCUS_FLOOR : n + 1) / 2 * 2 - 1;
      foc = ($urandom_range(0, 4) == 0);
    end else begin
      span = (n > 4) ? n : 4;
      foc = 1'($urandom_range(0, 1));
    end
    if ($urandom_range(0, 6) == 0) idx = IDX_W'($urandom_range(0, 63));
    else idx = IDX_W'($urandom_range(0, span - 1));
    send_tile(idx, foc);
  endtask

  function automatic logic [CFG_DATA_W-1:0] pick_frame_dim();
    case ($urandom_range(0, 15))
      0: return '0;
      1: return CFG_DATA_W'($urandom_range(1, 8));
      2: return CFG_DATA_W'(FRAME_CAP);
      3: return CFG_DATA_W'($urandom_range(FRAME_CAP + 1, 8191));
      default: return CFG_DATA_W'($urandom_range(1, FRAME_CAP));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_source_count();
    case ($urandom_range(0, 9))
      0: return CFG_DATA_W'($urandom_range(SOURCE_CAP + 1, 127));
      1: return CFG_DATA_W'(SOURCE_CAP);
      2: return '0;
      default: return CFG_DATA_W'($urandom_range(1, SOURCE_CAP - 1));
    endcase
  endfunction

  // layout after reset: 640x480, no sources, square grid of two
  task automatic test_reset_defaults();
    send_tile(6'd0, 1'b0);
    send_tile(6'd3, 1'b1);
    send_tile(6'd4, 1'b0);
    send_tile(6'd63, 1'b1);
  endtask

  // grid extremes: saturation, zero and narrow frames, tiles past the grid
  task automatic test_grid_edges();
    set_layout(13'd8191, 13'd4096, 13'd127, 1'b0);
    send_tile(6'd0, 1'b0);
    send_tile(6'd63, 1'b1);
    send_tile(6'd7, 1'b0);
    send_tile(6'd56, 1'b0);
    set_layout(13'd0, 13'd3, 13'd64, 1'b0);
    send_tile(6'd9, 1'b0);
    send_tile(6'd63, 1'b0);
    set_layout(13'd4096, 13'd1, 13'd5, 1'b0);
    send_tile(6'd8, 1'b0);
    send_tile(6'd9, 1'b0);
    send_tile(6'd9, 1'b1);
  endtask

  // focus layout: minimum and maximum slot counts, column and row ends
  task automatic test_focus_edges();
    set_layout(13'd640, 13'd480, 13'd0, 1'b1);
    send_tile(6'd0, 1'b1);
    send_tile(6'd2, 1'b0);
    send_tile(6'd3, 1'b0);
    send_tile(6'd4, 1'b0);
    send_tile(6'd5, 1'b0);
    send_tile(6'd63, 1'b1);
    set_layout(13'd4096, 13'd4096, 13'd64, 1'b1);
    send_tile(6'd31, 1'b0);
    send_tile(6'd32, 1'b0);
    send_tile(6'd62, 1'b0);
    send_tile(6'd63, 1'b0);
    send_tile(6'd0, 1'b1);
  endtask

  // random layouts under each idling pattern
  task automatic test_random_layouts();
    int send_pcts[4] = '{0, 84, 0, 34};
    int recv_pcts[4] = '{0, 0, 84, 34};
    for (int ph = 0; ph < 4; ph++) begin
      for (int k = 0; k < 4; k++) begin
        set_layout(pick_frame_dim(), pick_frame_dim(), pick_source_count(),
                   1'($urandom_range(0, 1)));
        send_idle_pct  = send_pcts[ph];
        recv_stall_pct = recv_pcts[ph];
        repeat (ITEMS_PER_SET) send_random_tile();
      end
    end
  endtask

  // long receiver hold-off fills the pipeline, then the receiver drains it out
  task automatic test_backpressure();
    set_layout(13'd1920, 13'd1080, 13'd9, 1'b1);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    fork
      begin
        rx_hold = 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
    join_none
    repeat (40) send_random_tile();
    wait_idle();
    repeat (40) send_random_tile();
    wait_idle();
  endtask

  // receiver side ready, random stalls or a held stretch
  initial begin
    rect_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold) rect_if.ready <= 1'b0;
      else rect_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // compare each rectangle with the oldest prediction
  always @(posedge clk) begin : rect_check
    tile_rect_t want, seen;
    if (!rst && rect_if.valid && rect_if.ready) begin
      seen = '{rect_if.rect_x, rect_if.rect_y, rect_if.rect_w, rect_if.rect_h,
               rect_if.visible};
      if (rect_expect.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_MAX)
          $display("unexpected rectangle x=%0d y=%0d w=%0d h=%0d vis=%0b",
                   seen.x, seen.y, seen.w, seen.h, seen.vis);
      end else begin
        want = rect_expect.pop_front();
        if (want.x !== seen.x || want.y !== seen.y || want.w !== seen.w ||
            want.h !== seen.h || want.vis !== seen.vis) begin
          fail_count++;
          if (fail_count <= REPORT_MAX) begin
            $display("rect mismatch: expected x=%0d y=%0d w=%0d h=%0d vis=%0b",
                     want.x, want.y, want.w, want.h, want.vis);
            $display("               got      x=%0d y=%0d w=%0d h=%0d vis=%0b",
                     seen.x, seen.y, seen.w, seen.h, seen.vis);
          end
        end
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (rst || (tile_if.valid && tile_if.ready) || (rect_if.valid && rect_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", quiet_cycles);
        $display("mixer_tile_layout verification failed");
        $finish;
      end
    end
  end

  initial begin
    tile_if.valid      = 1'b0;
    tile_if.tile_index = '0;
    tile_if.is_focused = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = REG_FRAME_WIDTH;
    cfg_data  = '0;
    repeat (3) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_grid_edges();
    test_focus_edges();
    test_random_layouts();
    test_backpressure();

    wait_idle();
    repeat (PIPE_SLACK) @(posedge clk);
    if (rect_expect.size() != 0) begin
      $display("%0d rectangles never arrived", rect_expect.size());
    end
    if (fail_count == 0 && rect_expect.size() == 0) begin
      $display("mixer_tile_layout verification clean");
    end else begin
      $display("mixer_tile_layout verification failed");
    end
    $finish;
  end

endmodule
